[hw/rtl/txp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txp_pkg
// Types, phase codes, character codes and helper functions shared by the
// text-to-integer parser.
// ----------------------------------------------------------------------------
package txp_pkg;

    // Parse phase codes. Codes five through seven are unused and behave as idle.
    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;

    localparam logic [5:0]  BASE_HEX  = 6'd16;
    localparam logic [5:0]  BASE_DEC  = 6'd10;
    localparam logic [5:0]  BASE_AUTO = 6'd0;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [5:0] NUMBER_BASE_RESET = 6'd10;

    typedef struct packed {
        logic [2:0]  phase;
        logic        negative_flag;
        logic [5:0]  active_base;
        logic [63:0] accumulator;
        logic [15:0] consumed_count;
    } t_parse_state;

    typedef struct packed {
        logic       ok;
        logic [5:0] value;
    } t_digit;

    localparam t_parse_state PARSE_CLEAR = '{
        phase:          PH_SPACE,
        negative_flag:  1'b0,
        active_base:    6'd0,
        accumulator:    64'd0,
        consumed_count: 16'd0
    };

    // Maps 0-9, a-z and A-Z onto digit values 0 to 35.
    function automatic t_digit digit_of(input logic [7:0] c);
        t_digit     d;
        logic [7:0] diff;
        d    = '{ok: 1'b0, value: 6'd0};
        diff = 8'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff = c - CH_ZERO;
            d    = '{ok: 1'b1, value: diff[5:0]};
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            diff = c - CH_LO_A + 8'd10;
            d    = '{ok: 1'b1, value: diff[5:0]};
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            diff = c - CH_UP_A + 8'd10;
            d    = '{ok: 1'b1, value: diff[5:0]};
        end
        return d;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] count);
        return (count == COUNT_MAX) ? count : count + 16'd1;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/txp_char_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txp_char_if
// Character channel: one beat carries one raw character and a start flag.
// ----------------------------------------------------------------------------
interface txp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       start_of_text;

    modport source (output valid, output char_in, output start_of_text, input ready);
    modport sink   (input valid, input char_in, input start_of_text, output ready);
endinterface

`default_nettype wire

[hw/rtl/txp_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txp_result_if
// Result channel: one beat carries a parsed value and its end offset.
// ----------------------------------------------------------------------------
interface txp_result_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] parsed_value;
    logic        [15:0] end_offset;

    modport source (output valid, output parsed_value, output end_offset, input ready);
    modport sink   (input valid, input parsed_value, input end_offset, output ready);
endinterface

`default_nettype wire

[hw/rtl/txp_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// txp_step
// Combinational parse step: next parse state and an optional result for one
// character.
// ----------------------------------------------------------------------------
module txp_step
    import txp_pkg::*;
(
    input  t_parse_state i_state,
    input  logic [7:0]   i_char,
    input  logic         i_start,
    input  logic [5:0]   i_number_base,
    output t_parse_state o_next,
    output logic         o_emit,
    output logic [63:0]  o_value,
    output logic [15:0]  o_offset
);

    t_parse_state s;
    t_digit       dig;
    logic         do_take;
    logic [5:0]   take_base;
    logic [69:0]  product;
    logic         is_space;
    logic         is_sign;
    logic         is_x;
    logic         zero_prefix;

    assign s   = i_start ? PARSE_CLEAR : i_state;
    assign dig = digit_of(i_char);

    assign is_space    = (i_char == CH_SPACE) || (i_char == CH_TAB);
    assign is_sign     = (i_char == CH_PLUS) || (i_char == CH_MINUS);
    assign is_x        = (i_char == CH_LO_X) || (i_char == CH_UP_X);
    assign zero_prefix = ((i_number_base == BASE_HEX) || (i_number_base == BASE_AUTO))
                         && (i_char == CH_ZERO);

    // The only multiplier: accumulator times a six-bit base.
    assign product = s.accumulator * {64'd0, take_base};

    always_comb begin
        o_next    = s;
        o_emit    = 1'b0;
        o_value   = 64'd0;
        o_offset  = s.consumed_count;
        do_take   = 1'b0;
        take_base = s.active_base;

        unique case (s.phase)
            PH_SPACE, PH_SIGNED: begin
                if (s.phase == PH_SPACE && is_space) begin
                    o_next.consumed_count = sat_inc(s.consumed_count);
                end else if (s.phase == PH_SPACE && is_sign) begin
                    o_next.negative_flag  = (i_char == CH_MINUS);
                    o_next.consumed_count = sat_inc(s.consumed_count);
                    o_next.phase          = PH_SIGNED;
                end else if (zero_prefix) begin
                    o_next.active_base    = i_number_base;
                    o_next.consumed_count = sat_inc(s.consumed_count);
                    o_next.phase          = PH_ZERO;
                end else begin
                    do_take   = 1'b1;
                    take_base = (i_number_base == BASE_AUTO) ? BASE_DEC : i_number_base;
                end
            end
            PH_ZERO: begin
                if (is_x) begin
                    o_next.active_base    = BASE_HEX;
                    o_next.consumed_count = sat_inc(s.consumed_count);
                    o_next.phase          = PH_DIGITS;
                end else begin
                    do_take   = 1'b1;
                    take_base = (s.active_base == BASE_AUTO) ? BASE_DEC : s.active_base;
                end
            end
            PH_DIGITS: begin
                do_take = 1'b1;
            end
            default: begin
            end
        endcase

        if (do_take) begin
            o_next.active_base = take_base;
            if (dig.ok && dig.value < take_base) begin
                o_next.accumulator    = product[63:0] + {58'd0, dig.value};
                o_next.consumed_count = sat_inc(s.consumed_count);
                o_next.phase          = PH_DIGITS;
            end else begin
                o_emit       = 1'b1;
                o_value      = s.negative_flag ? (64'd0 - s.accumulator) : s.accumulator;
                o_next.phase = PH_IDLE;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/text_to_integer_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_to_integer_parser
// Character-serial signed integer parser in the style of strtol.
// ----------------------------------------------------------------------------
// The parser takes one character beat per clock cycle unless a terminating
// character meets a full result register that is not being drained, which
// stalls the character channel. Each character goes into an input register,
// one parse step (compare logic plus a 64 by 6 bit multiply-add on the
// accumulator) updates the parse state, and the terminating character loads
// the result register, from which its result beat is offered. The parse
// state recurs through that single multiply-add, which sets the rate of one
// character per cycle. Leading spaces and tabs and one sign are skipped and
// counted; in base 16 or base 0 a leading 0x or 0X is skipped, and base 0
// means hexadecimal with that prefix and decimal without it. The first
// character that is not a digit below the base yields one result beat with
// the value (negated for a minus sign, wrapping modulo 2^64) and the
// saturating count of characters consumed. The parser then ignores
// characters until one arrives with start_of_text set. The number_base
// register sits at byte address 0 and is read when a parse leaves the sign
// phase; write it only while the parser is idle.
// ----------------------------------------------------------------------------
module text_to_integer_parser
    import txp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    txp_char_if.sink          i_char_bus,
    txp_result_if.source      o_result_bus,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic      [31:0]  prdata,
    output logic              pready
);

    // Configuration register.
    logic [5:0] r_number_base;
    logic       cfg_write;

    // Input register stage.
    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_sot;

    // Parse state and result register.
    t_parse_state r_state;
    t_parse_state n_state;
    logic         r_out_valid;
    logic [63:0]  r_out_value;
    logic [15:0]  r_out_offset;

    logic        step_emit;
    logic [63:0] step_value;
    logic [15:0] step_offset;
    logic        advance;
    logic        in_take;

    // The byte address holds the register index in bit 2; only index 0 exists.
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {26'd0, r_number_base} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_number_base <= NUMBER_BASE_RESET;
        end else if (cfg_write) begin
            r_number_base <= pwdata[5:0];
        end
    end

    txp_step u_step (
        .i_state       (r_state),
        .i_char        (r_in_char),
        .i_start       (r_in_sot),
        .i_number_base (r_number_base),
        .o_next        (n_state),
        .o_emit        (step_emit),
        .o_value       (step_value),
        .o_offset      (step_offset)
    );

    // The held character is processed unless it ends a number while the
    // result register is still full and not being drained.
    assign advance = r_in_valid && (!step_emit || !r_out_valid || o_result_bus.ready);
    assign i_char_bus.ready = !r_in_valid || advance;
    assign in_take = i_char_bus.valid && i_char_bus.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_char_bus.char_in;
            r_in_sot  <= i_char_bus.start_of_text;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PARSE_CLEAR;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && step_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_result_bus.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && step_emit) begin
            r_out_value  <= step_value;
            r_out_offset <= step_offset;
        end
    end

    assign o_result_bus.valid        = r_out_valid;
    assign o_result_bus.parsed_value = r_out_value;
    assign o_result_bus.end_offset   = r_out_offset;

    // A terminator always leaves the parser idle.
    a_emit_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && step_emit |=> r_state.phase == PH_IDLE)
        else $error("parser not idle after a result");

    // Without a start flag the consumed count never goes down.
    a_count_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_sot |=> r_state.consumed_count >= $past(r_state.consumed_count))
        else $error("consumed count decreased");

    // A held character that cannot advance is not overwritten.
    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_in_char) && $stable(r_in_sot))
        else $error("stalled character lost");

    // A stalled result is never replaced by the next one.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_result_bus.ready |-> !(advance && step_emit))
        else $error("result register overrun");

endmodule

`default_nettype wire

[tb/tb_text_to_integer_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_to_integer_parser
// Self-checking bench for the character-serial integer parser. Character
// beats are driven with random gaps, and the bench keeps its own model of the
// parse to predict every result beat. The number base is changed over an APB
// write between phases and read back after each write.
// ----------------------------------------------------------------------------
module tb_text_to_integer_parser
    import txp_pkg::*;
;

    localparam int         CYCLE_LIMIT      = 600000;
    localparam int         DRAIN_CYCLES     = 8;
    localparam int         HOLD_CYCLES      = 400;
    localparam int         ITEMS_PER_PHASE  = 125;
    localparam int         NO_DIGIT         = 255;
    localparam int         REPORT_LINES_MAX = 100;
    localparam logic [2:0] NUMBER_BASE_ADDR = 3'd0;
    localparam logic [2:0] UNUSED_ADDR      = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       sot;
    } t_char_beat;

    typedef struct packed {
        logic [63:0] value;
        logic [15:0] offset;
    } t_parse_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    txp_char_if   chr();
    txp_result_if res();

    text_to_integer_parser dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_char_bus   (chr),
        .o_result_bus (res),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #6 i_clk = ~i_clk;

    // Characters waiting to be offered, and results the parser still owes us.
    t_char_beat    text_beats[$];
    t_parse_result expected_results[$];
    t_char_beat    offered_beat;
    t_parse_result oldest_result;

    // Our copy of the parse state and of the base register.
    logic [2:0]  st_phase = PH_SPACE;
    logic        st_neg   = 1'b0;
    logic [5:0]  st_base  = 6'd0;
    logic [63:0] st_acc   = 64'd0;
    logic [15:0] st_count = 16'd0;
    logic [5:0]  cfg_base = NUMBER_BASE_RESET;

    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   hold_left      = 0;
    logic hold_used      = 1'b0;
    logic hold_request   = 1'b0;
    logic steady         = 1'b0;

    logic [5:0] random_bases[10] = '{6'd10, 6'd16, 6'd0, 6'd36, 6'd2,
                                     6'd1, 6'd63, 6'd8, 6'd37, 6'd16};

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LINES_MAX) begin
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        end
        mismatch_count++;
    endtask

    // Digit value of a character for any base up to 36; NO_DIGIT otherwise.
    function automatic int digit_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c - CH_ZERO);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            return int'(c - CH_LO_A) + 10;
        end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
            return int'(c - CH_UP_A) + 10;
        end
        return NO_DIGIT;
    endfunction

    task automatic count_consumed();
        if (st_count != COUNT_MAX) begin
            st_count = st_count + 16'd1;
        end
    endtask

    // Either folds a digit into the accumulator or ends the number. The
    // terminator itself is not counted.
    task automatic fold_or_terminate(input logic [7:0] c);
        int            d;
        t_parse_result r;
        d = digit_value(c);
        if (d < st_base) begin
            st_acc = st_acc * 64'(st_base) + 64'(d);
            count_consumed();
        end else begin
            r.value  = st_neg ? 64'd0 - st_acc : st_acc;
            r.offset = st_count;
            expected_results.push_back(r);
            st_phase = PH_IDLE;
        end
    endtask

    // The base register is sampled here, on leaving the sign phase. A leading
    // zero in base 16 or auto base may open a 0x prefix.
    task automatic leave_sign_phase(input logic [7:0] c);
        if ((cfg_base == BASE_HEX || cfg_base == BASE_AUTO) && c == CH_ZERO) begin
            st_base  = cfg_base;
            count_consumed();
            st_phase = PH_ZERO;
        end else begin
            st_base  = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
            st_phase = PH_DIGITS;
            fold_or_terminate(c);
        end
    endtask

    task automatic parse_char_beat(input logic [7:0] c, input logic sot);
        if (sot) begin
            st_phase = PH_SPACE;
            st_neg   = 1'b0;
            st_base  = 6'd0;
            st_acc   = 64'd0;
            st_count = 16'd0;
        end
        case (st_phase)
            PH_SPACE: begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    count_consumed();
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    st_neg   = (c == CH_MINUS);
                    count_consumed();
                    st_phase = PH_SIGNED;
                end else begin
                    leave_sign_phase(c);
                end
            end
            PH_SIGNED: begin
                leave_sign_phase(c);
            end
            PH_ZERO: begin
                st_phase = PH_DIGITS;
                if (c == CH_LO_X || c == CH_UP_X) begin
                    st_base = BASE_HEX;
                    count_consumed();
                end else begin
                    if (st_base == BASE_AUTO) begin
                        st_base = BASE_DEC;
                    end
                    fold_or_terminate(c);
                end
            end
            PH_DIGITS: begin
                fold_or_terminate(c);
            end
            default: begin
                // Idle after a terminator: nothing happens until a start flag.
            end
        endcase
    endtask

    function automatic bit idle_this_cycle();
        return !steady && ($urandom_range(99) < 19);
    endfunction

    // Character driver. The previous beat is predicted when it is taken, and
    // the next one is put on the bus in the same step with a single update.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            chr.valid <= 1'b0;
        end else begin
            if (chr.valid && chr.ready) begin
                parse_char_beat(chr.char_in, chr.start_of_text);
            end
            if (!chr.valid || chr.ready) begin
                if (text_beats.size() != 0 && !idle_this_cycle()) begin
                    offered_beat          = text_beats.pop_front();
                    chr.valid            <= 1'b1;
                    chr.char_in          <= offered_beat.ch;
                    chr.start_of_text    <= offered_beat.sot;
                end else begin
                    chr.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off. It runs once, on request, so the parser fills
    // up and has to push back on the character channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_used <= 1'b0;
        end else if (hold_request && !hold_used) begin
            hold_left <= HOLD_CYCLES;
            hold_used <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            res.ready <= (hold_left == 0) && !idle_this_cycle();
        end
    end

    // Result monitor: every accepted result beat must match the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %h offset %0d",
                                          res.parsed_value, res.end_offset));
            end else begin
                oldest_result = expected_results.pop_front();
                if (res.parsed_value !== oldest_result.value) begin
                    report_mismatch($sformatf("parsed_value %h, expected %h",
                                              res.parsed_value, oldest_result.value));
                end
                if (res.end_offset !== oldest_result.offset) begin
                    report_mismatch($sformatf("end_offset %0d, expected %0d",
                                              res.end_offset, oldest_result.offset));
                end
            end
        end
    end

    // Watchdog: a hung parser ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic add_beat(input logic [7:0] c, input logic sot);
        text_beats.push_back('{ch: c, sot: sot});
    endtask

    // Queues a string; only its first character may carry the start flag.
    task automatic add_text(input string s, input bit lead);
        int i;
        for (i = 0; i < s.len(); i++) begin
            add_beat(s[i], lead && (i == 0));
        end
    endtask

    // One random string for the given base register value. Most are well
    // formed (whitespace, sign, optional prefix, digits, terminator), the rest
    // are raw noise. Trailing characters after the terminator are not counted.
    task automatic add_random_text(input logic [5:0] radix, inout int items);
        int         i;
        int         pad;
        int         digits;
        int         lim;
        int         v;
        bit         lead;
        logic [7:0] b;
        if ($urandom_range(99) < 15) begin
            digits = $urandom_range(6, 1);
            for (i = 0; i < digits; i++) begin
                add_beat(8'($urandom_range(255)),
                         (i == 0) ? 1'($urandom_range(1)) : ($urandom_range(9) == 0));
            end
            items += digits;
        end else begin
            lead = ($urandom_range(19) != 0);
            pad  = $urandom_range(3);
            for (i = 0; i < pad; i++) begin
                add_beat($urandom_range(1) ? CH_SPACE : CH_TAB, lead);
                lead = 1'b0;
            end
            items += pad;
            if ($urandom_range(1)) begin
                add_beat($urandom_range(1) ? CH_MINUS : CH_PLUS, lead);
                lead = 1'b0;
                items++;
            end
            lim = (radix == BASE_AUTO) ? 10 : int'(radix);
            if ((radix == BASE_HEX || radix == BASE_AUTO) && $urandom_range(99) < 40) begin
                add_beat(CH_ZERO, lead);
                add_beat($urandom_range(1) ? CH_LO_X : CH_UP_X, 1'b0);
                lead  = 1'b0;
                lim   = 16;
                items += 2;
            end
            if (lim > 36) begin
                lim = 36;
            end
            digits = ($urandom_range(3) == 0) ? $urandom_range(22) : $urandom_range(6, 1);
            for (i = 0; i < digits; i++) begin
                v = $urandom_range(lim - 1);
                if (v < 10) begin
                    b = CH_ZERO + 8'(v);
                end else begin
                    b = ($urandom_range(1) ? CH_LO_A : CH_UP_A) + 8'(v - 10);
                end
                add_beat(b, lead);
                lead = 1'b0;
            end
            items += digits;
            do begin
                b = 8'($urandom_range(255));
            end while (digit_value(b) < lim);
            add_beat(b, lead);
            items++;
            // Trailing characters after the terminator are ignored.
            if ($urandom_range(4) == 0) begin
                pad = $urandom_range(3, 1);
                for (i = 0; i < pad; i++) begin
                    add_beat(8'($urandom_range(255)), 1'b0);
                end
            end
        end
    endtask

    // Waits until every queued beat has gone in and every result has come
    // out, then lets the parser's two-stage pipeline settle, since the last
    // character may have produced no result.
    task automatic drain_parser();
        while (text_beats.size() != 0 || chr.valid) begin
            @(negedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, written at the end of access.
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == NUMBER_BASE_ADDR) begin
            cfg_base = data[5:0];
        end
    endtask

    task automatic check_base_readback();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= NUMBER_BASE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[5:0] !== cfg_base) begin
            report_mismatch($sformatf("number_base reads %0d, expected %0d",
                                      prdata[5:0], cfg_base));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Base changes happen only with the parser drained. The next characters
    // are queued on a falling edge, away from the driver's sampling edge.
    task automatic retune_base(input logic [31:0] data);
        drain_parser();
        apb_write(NUMBER_BASE_ADDR, data);
        check_base_readback();
        @(negedge i_clk);
    endtask

    initial begin
        int items;
        int i;
        int p;

        chr.valid         = 1'b0;
        chr.char_in       = 8'd0;
        chr.start_of_text = 1'b0;
        res.ready         = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = 3'd0;
        pwdata            = 32'd0;
        i_rst_n           = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The base must come out of reset as decimal.
        check_base_readback();
        @(negedge i_clk);

        // Decimal. The very first string has no start flag, which must still
        // parse normally out of reset.
        add_text("  \t-42;", 1'b0);
        add_text("5 9", 1'b1);                   // the 9 follows a terminator
        add_text("+x", 1'b1);                    // sign with no digits
        add_text(" \t,", 1'b1);                  // whitespace only
        add_text("-9223372036854775808 ", 1'b1);
        add_text("99999999999999999999!", 1'b1); // wraps past 2^64
        add_text("-0x5", 1'b1);                  // zero then x ends in base 10
        add_text("12", 1'b1);
        add_beat(8'hFF, 1'b0);
        add_text("3", 1'b1);
        add_beat(8'h00, 1'b0);

        // Hexadecimal, with and without the prefix.
        retune_base(32'd16);
        add_text("0x1F;", 1'b1);
        add_text("-0XfF.", 1'b1);
        add_text("0xg", 1'b1);                   // prefix with no digits
        add_text("0g", 1'b1);                    // zero not followed by x
        add_text("+0x7fffffffffffffff,", 1'b1);
        add_text("abc ", 1'b1);

        // Auto base: hex after a prefix, else decimal, never octal.
        retune_base(32'd0);
        add_text("0x1a!", 1'b1);
        add_text("012:", 1'b1);
        add_text("0 ", 1'b1);
        add_text("-0Xz", 1'b1);

        // Base one accepts only zero.
        retune_base(32'd1);
        add_text("0001", 1'b1);

        retune_base(32'd36);
        add_text("zZ9.", 1'b1);

        // Above 36 every digit is taken; upper data bits must be dropped.
        retune_base(32'hFFFF_FFFF);
        add_text("zz~", 1'b1);
        add_text("-Zy0 ", 1'b1);

        // A write to an unmapped address leaves the base alone.
        drain_parser();
        apb_write(UNUSED_ADDR, 32'h0000_0010);
        check_base_readback();

        // Random strings across a spread of bases. The first phase runs
        // without gaps; in the second the receiver stalls for a long stretch.
        for (p = 0; p < 10; p++) begin
            retune_base(($urandom() & 32'hFFFF_FFC0) | {26'd0, random_bases[p]});
            items = 0;
            while (items < ITEMS_PER_PHASE) begin
                add_random_text(random_bases[p], items);
            end
            steady <= (p == 0);
            if (p == 1) begin
                hold_request <= 1'b1;
            end
        end

        drain_parser();
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[text_to_integer_parser.f]
hw/rtl/txp_pkg.sv
hw/rtl/txp_char_if.sv
hw/rtl/txp_result_if.sv
hw/rtl/txp_step.sv
hw/rtl/text_to_integer_parser.sv
tb/tb_text_to_integer_parser.sv
